### rtl/core/assert_macros.svh
// Assertion helpers shared by the line point generator modules.
// Each macro samples on the rising edge of clk and is masked while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled edge.
`define LPG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define LPG_ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define LPG_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lpg_pkg.sv
package lpg_pkg;

  localparam int COORD_BITS = 6;
  // The decision term spans roughly -2*dmajor .. 2*dminor, so three extra bits suffice.
  localparam int DEC_W      = COORD_BITS + 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_W-1:0] dec_t;

  // A classified segment, ready for the stepping engine.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   neg_x;
    logic   neg_y;
    logic   x_major;
    coord_t dmajor;
    coord_t dminor;
    dec_t   dec;
  } seg_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/lpg_front.sv
module lpg_front (
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  lpg_pkg::coord_t       start_x,
  input  lpg_pkg::coord_t       start_y,
  input  lpg_pkg::coord_t       end_x,
  input  lpg_pkg::coord_t       end_y,
  input  lpg_pkg::q_status_t    q_stat,
  output logic                  push,
  output lpg_pkg::seg_desc_t    desc
);

  lpg_pkg::coord_t adx;
  lpg_pkg::coord_t ady;
  logic            neg_x;
  logic            neg_y;
  logic            x_major;
  lpg_pkg::coord_t dmaj;
  lpg_pkg::coord_t dmin;

  always_comb begin
    neg_x   = end_x < start_x;
    neg_y   = end_y < start_y;
    adx     = neg_x ? (start_x - end_x) : (end_x - start_x);
    ady     = neg_y ? (start_y - end_y) : (end_y - start_y);
    x_major = adx >= ady;
    dmaj    = x_major ? adx : ady;
    dmin    = x_major ? ady : adx;

    desc.x       = start_x;
    desc.y       = start_y;
    desc.neg_x   = neg_x;
    desc.neg_y   = neg_y;
    desc.x_major = x_major;
    desc.dmajor  = dmaj;
    desc.dminor  = dmin;
    desc.dec     = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  end

  assign seg_stall = q_stat.full;
  assign push      = seg_valid && !q_stat.full;

endmodule

### rtl/core/lpg_queue.sv
`include "assert_macros.svh"

module lpg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lpg_pkg::seg_desc_t    push_desc,
  input  logic                  pop,
  output lpg_pkg::seg_desc_t    pop_desc,
  output lpg_pkg::q_status_t    q_stat
);

  lpg_pkg::seg_desc_t            mem [lpg_pkg::Q_DEPTH];
  logic [lpg_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [lpg_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [lpg_pkg::Q_CNT_W-1:0]   count;

  localparam logic [lpg_pkg::Q_CNT_W-1:0] DEPTH_C = lpg_pkg::Q_CNT_W'(lpg_pkg::Q_DEPTH);
  localparam logic [lpg_pkg::Q_PTR_W-1:0] LAST_C  = lpg_pkg::Q_PTR_W'(lpg_pkg::Q_DEPTH - 1);

  assign q_stat.full  = count == DEPTH_C;
  assign q_stat.empty = count == '0;
  assign pop_desc     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `LPG_ASSERT_ALWAYS(a_count_bound, count <= DEPTH_C, "queue count beyond depth")
  `LPG_ASSERT_IMPLIES(a_no_overflow, push, !q_stat.full, "word pushed into a full queue")
  `LPG_ASSERT_IMPLIES(a_no_underflow, pop, !q_stat.empty, "word popped from an empty queue")
  `LPG_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + 1'b1,
                   "queue count did not grow on push")

endmodule

### rtl/core/lpg_back.sv
module lpg_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lpg_pkg::q_status_t    q_stat,
  input  lpg_pkg::seg_desc_t    desc,
  output logic                  pop,
  output logic                  point_valid,
  input  logic                  point_stall,
  output lpg_pkg::coord_t       point_x,
  output lpg_pkg::coord_t       point_y,
  output logic                  last_point
);

  logic            busy;
  lpg_pkg::coord_t x;
  lpg_pkg::coord_t y;
  lpg_pkg::dec_t   dec;
  lpg_pkg::coord_t remain;
  lpg_pkg::coord_t dmajor;
  lpg_pkg::coord_t dminor;
  logic            neg_x;
  logic            neg_y;
  logic            x_major;

  logic            adv;
  logic            minor_step;
  lpg_pkg::coord_t step_x;
  lpg_pkg::coord_t step_y;
  lpg_pkg::dec_t   dec_next;
  lpg_pkg::coord_t x_next;
  lpg_pkg::coord_t y_next;

  always_comb begin
    adv        = busy && (!point_valid || !point_stall);
    pop        = !busy && !q_stat.empty;
    minor_step = !dec[lpg_pkg::DEC_W-1];
    step_x     = neg_x ? '1 : lpg_pkg::COORD_BITS'(1);
    step_y     = neg_y ? '1 : lpg_pkg::COORD_BITS'(1);
    dec_next   = dec + $signed({2'b00, dminor, 1'b0})
                 - (minor_step ? $signed({2'b00, dmajor, 1'b0}) : '0);
    x_next     = (x_major || minor_step) ? x + step_x : x;
    y_next     = (!x_major || minor_step) ? y + step_y : y;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x       <= desc.x;
      y       <= desc.y;
      dec     <= desc.dec;
      remain  <= desc.dmajor;
      dmajor  <= desc.dmajor;
      dminor  <= desc.dminor;
      neg_x   <= desc.neg_x;
      neg_y   <= desc.neg_y;
      x_major <= desc.x_major;
    end else if (adv) begin
      x      <= x_next;
      y      <= y_next;
      dec    <= dec_next;
      remain <= remain - 1'b1;
    end
    if (adv) begin
      point_x    <= x;
      point_y    <= y;
      last_point <= remain == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (adv && remain == '0) begin
        busy <= 1'b0;
      end
      if (adv) begin
        point_valid <= 1'b1;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/line_point_generator_core.sv
// Line point generator: Bresenham rasterizer for segments on a 64 by 64 grid.
// The segment channel (seg_valid, seg_stall, start_x/start_y/end_x/end_y)
// takes one word per segment. The point channel (point_valid, point_stall,
// point_x/point_y/last_point) returns every grid point of the segment from
// start to end, one word per point, with last_point set on the end point.
// A segment yields dmajor + 1 points, where dmajor is the larger of |dx| and
// |dy|, so between 1 and 64 points.
// An accepted segment waits in the queue until the engine is free, is loaded
// into the engine and then yields its first point in the output register;
// one point then follows every cycle while point_stall is low. The engine
// takes the next segment from the queue only after the last point of this one.
// A two-word queue sits between classification and stepping, so segments are
// taken while the engine still works; seg_stall rises when the queue is full.
// When the receiver holds point_stall, the current point holds in the output
// register and stepping pauses until that point is taken.
// Reset (rst, synchronous, active high) empties the queue, drops any segment
// in progress and clears point_valid.
module line_point_generator_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  lpg_pkg::coord_t       start_x,
  input  lpg_pkg::coord_t       start_y,
  input  lpg_pkg::coord_t       end_x,
  input  lpg_pkg::coord_t       end_y,
  output logic                  point_valid,
  input  logic                  point_stall,
  output lpg_pkg::coord_t       point_x,
  output lpg_pkg::coord_t       point_y,
  output logic                  last_point
);

  // Front to queue: the classified segment and its push strobe.
  logic               push;
  lpg_pkg::seg_desc_t push_desc;
  // Queue to back: the head word and the fill status shared by both sides.
  logic               pop;
  lpg_pkg::seg_desc_t pop_desc;
  lpg_pkg::q_status_t q_stat;

  // The front works out deltas, directions, the major axis and the starting
  // decision term in the same cycle that it accepts the word.
  lpg_front u_front (
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .q_stat    (q_stat),
    .push      (push),
    .desc      (push_desc)
  );

  lpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_stat    (q_stat)
  );

  // The back steps the major coordinate once per point and moves the minor
  // coordinate whenever the decision term is not negative.
  lpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .desc        (pop_desc),
    .pop         (pop),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point)
  );

endmodule
